// File: rtl/etp_pkg.sv
// etp_pkg: shared types and constants for the exclusive-time profiler
// used by exclusive_time_profiler, etp_alu and etp_checker; no dependencies

package etp_pkg;

  localparam int NUM_FUNCS_DEF   = 128;
  localparam int STACK_DEPTH_DEF = 128;

  localparam int ALU_W = 34;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_END   = 2'd1;
  localparam int         MODE_READ_BIT = 1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_BACK  = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [6:0]  function_id;
    logic [31:0] timestamp;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        credited;
    logic [6:0]  credited_id;
    logic [31:0] total;
    logic [7:0]  stack_depth;
  } out_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

endpackage

// File: rtl/etp_alu.sv
// etp_alu: shared add/subtract unit of the profiler sequencer
// depends on etp_pkg

module etp_alu (
  input  etp_pkg::alu_req_t         req,
  output logic [etp_pkg::ALU_W-1:0] res
);

  logic [etp_pkg::ALU_W-1:0] b_op;

  assign b_op = req.sub ? ~req.b : req.b;
  assign res  = req.a + b_op + etp_pkg::ALU_W'(req.sub);

endmodule

// File: rtl/exclusive_time_profiler.sv
// exclusive_time_profiler: call-stack profiler keeping exclusive time per function
// depends on etp_pkg and etp_alu
//
// usage:
//   input channel in_valid/in_stall/in_data carries one trace event per transaction:
//   a function start, a function end or a read of one function total.
//   output channel out_valid/out_stall/out_data returns exactly one result per event.
//   after reset the totals memory is swept to zero, one entry per cycle, all NUM_FUNCS
//   entries; in_stall stays high during that sweep.
//   each event is handled by a small sequencer around one shared 34-bit adder:
//   extend time, compare/subtract against the previous mark, then add and saturate
//   into the totals memory (registered read, read-modify-write).
//   an accepted event passes through the extend and check states, then the update
//   state when a total is read or credited, then the output state; the next event is
//   accepted only once the result of the last one is loaded into the output register.
//   a finished result sits in the output register; the block accepts the next event
//   while it waits, but holds its next result until the receiver drops out_stall.
//   errors (end on empty stack, start on full stack, time backwards) leave state as is.

module exclusive_time_profiler #(
  parameter int NUM_FUNCS   = etp_pkg::NUM_FUNCS_DEF,
  parameter int STACK_DEPTH = etp_pkg::STACK_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  etp_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output etp_pkg::out_t  out_data
);

  localparam int FIDX_W = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
  localparam int SIDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXT,
    S_CHK,
    S_UPD,
    S_OUT
  } state_t;

  state_t                    state_r, state_nxt;
  logic [FIDX_W-1:0]         clr_idx_r, clr_idx_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [32:0]               prev_mark_r, prev_mark_nxt;
  etp_pkg::in_t              in_r, in_nxt;
  logic [32:0]               now_r, now_nxt;
  logic [32:0]               amt_r, amt_nxt;
  logic [1:0]                status_r, status_nxt;
  logic                      cred_r, cred_nxt;
  logic [6:0]                cid_r, cid_nxt;
  logic [31:0]               total_r, total_nxt;
  logic [FIDX_W-1:0]         tot_addr_r, tot_addr_nxt;
  etp_pkg::out_t             out_r, out_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic [6:0]                stack_q_r;
  logic [31:0]               tot_q_r;
  logic [6:0]                call_stack [STACK_DEPTH];
  logic [31:0]               totals [NUM_FUNCS];

  etp_pkg::alu_req_t         alu_req;
  logic [etp_pkg::ALU_W-1:0] alu_res;

  logic                      stk_we;
  logic [SIDX_W-1:0]         stk_wa;
  logic [SIDX_W-1:0]         top_idx;
  logic                      tot_re;
  logic [FIDX_W-1:0]         tot_ra;
  logic                      tot_we;
  logic [FIDX_W-1:0]         tot_wa;
  logic [31:0]               tot_wd;
  logic                      out_take;
  logic                      back;
  logic                      top_ok;
  logic                      fid_ok;
  logic [15:0]               cnt_ext;

  etp_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign top_idx  = SIDX_W'(count_r - CNT_W'(1));
  assign stk_wa   = SIDX_W'(count_r);
  assign back     = alu_res[etp_pkg::ALU_W-1];
  assign top_ok   = 32'(stack_q_r) < NUM_FUNCS;
  assign fid_ok   = 32'(in_r.function_id) < NUM_FUNCS;
  assign out_take = out_valid_r && !out_stall;
  assign cnt_ext  = 16'(count_nxt);

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    count_nxt     = count_r;
    prev_mark_nxt = prev_mark_r;
    in_nxt        = in_r;
    now_nxt       = now_r;
    amt_nxt       = amt_r;
    status_nxt    = status_r;
    cred_nxt      = cred_r;
    cid_nxt       = cid_r;
    total_nxt     = total_r;
    tot_addr_nxt  = tot_addr_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    alu_req       = '0;
    stk_we        = 1'b0;
    tot_re        = 1'b0;
    tot_ra        = tot_addr_r;
    tot_we        = 1'b0;
    tot_wa        = tot_addr_r;
    tot_wd        = alu_res[31:0];

    if (out_take) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        tot_we      = 1'b1;
        tot_wa      = clr_idx_r;
        tot_wd      = '0;
        clr_idx_nxt = clr_idx_r + FIDX_W'(1);
        if (clr_idx_r == FIDX_W'(NUM_FUNCS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          state_nxt = S_EXT;
        end
      end
      S_EXT: begin
        alu_req.a = etp_pkg::ALU_W'(in_r.timestamp);
        alu_req.b = etp_pkg::ALU_W'(in_r.mode[0]);
        now_nxt   = alu_res[32:0];
        state_nxt = S_CHK;
      end
      S_CHK: begin
        alu_req.a   = etp_pkg::ALU_W'(now_r);
        alu_req.b   = etp_pkg::ALU_W'(prev_mark_r);
        alu_req.sub = 1'b1;
        status_nxt  = etp_pkg::ST_OK;
        cred_nxt    = 1'b0;
        cid_nxt     = '0;
        total_nxt   = '0;
        amt_nxt     = alu_res[32:0];
        state_nxt   = S_OUT;
        if (in_r.mode[etp_pkg::MODE_READ_BIT]) begin
          cid_nxt = in_r.function_id;
          if (fid_ok) begin
            tot_re       = 1'b1;
            tot_ra       = FIDX_W'(in_r.function_id);
            tot_addr_nxt = FIDX_W'(in_r.function_id);
            state_nxt    = S_UPD;
          end
        end else if (in_r.mode == etp_pkg::MODE_START) begin
          if (count_r == CNT_W'(STACK_DEPTH)) begin
            status_nxt = etp_pkg::ST_FULL;
          end else if (back) begin
            status_nxt = etp_pkg::ST_BACK;
          end else begin
            stk_we        = 1'b1;
            count_nxt     = count_r + CNT_W'(1);
            prev_mark_nxt = now_r;
            if (count_r != '0 && top_ok) begin
              tot_re       = 1'b1;
              tot_ra       = FIDX_W'(stack_q_r);
              tot_addr_nxt = FIDX_W'(stack_q_r);
              cid_nxt      = stack_q_r;
              state_nxt    = S_UPD;
            end
          end
        end else begin
          if (count_r == '0) begin
            status_nxt = etp_pkg::ST_EMPTY;
          end else if (back) begin
            status_nxt = etp_pkg::ST_BACK;
          end else begin
            count_nxt     = count_r - CNT_W'(1);
            prev_mark_nxt = now_r;
            if (top_ok) begin
              tot_re       = 1'b1;
              tot_ra       = FIDX_W'(stack_q_r);
              tot_addr_nxt = FIDX_W'(stack_q_r);
              cid_nxt      = stack_q_r;
              state_nxt    = S_UPD;
            end
          end
        end
      end
      S_UPD: begin
        if (in_r.mode[etp_pkg::MODE_READ_BIT]) begin
          total_nxt = tot_q_r;
        end else begin
          alu_req.a = etp_pkg::ALU_W'(tot_q_r);
          alu_req.b = etp_pkg::ALU_W'(amt_r);
          total_nxt = (|alu_res[33:32]) ? '1 : alu_res[31:0];
          tot_we    = 1'b1;
          tot_wa    = tot_addr_r;
          tot_wd    = total_nxt;
          cred_nxt  = 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_take) begin
          out_valid_nxt       = 1'b1;
          out_nxt.status      = status_r;
          out_nxt.credited    = cred_r;
          out_nxt.credited_id = cid_r;
          out_nxt.total       = total_r;
          out_nxt.stack_depth = cnt_ext[7:0];
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      count_r     <= '0;
      prev_mark_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      count_r     <= count_nxt;
      prev_mark_r <= prev_mark_nxt;
      out_valid_r <= out_valid_nxt;
    end
    in_r       <= in_nxt;
    now_r      <= now_nxt;
    amt_r      <= amt_nxt;
    status_r   <= status_nxt;
    cred_r     <= cred_nxt;
    cid_r      <= cid_nxt;
    total_r    <= total_nxt;
    tot_addr_r <= tot_addr_nxt;
    out_r      <= out_nxt;
  end

  // call stack: top read while idle, push written during the check step
  always_ff @(posedge clk) begin
    if (stk_we) begin
      call_stack[stk_wa] <= in_r.function_id;
    end
    if (state_r == S_IDLE && count_r != '0) begin
      stack_q_r <= call_stack[top_idx];
    end
  end

  // totals: registered read, single write port
  always_ff @(posedge clk) begin
    if (tot_we) begin
      totals[tot_wa] <= tot_wd;
    end
    if (tot_re) begin
      tot_q_r <= totals[tot_ra];
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/etp_checker.sv
// etp_checker: port-level assertions for exclusive_time_profiler, with its bind
// depends on etp_pkg

module etp_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input etp_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input etp_pkg::out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  // one event at a time: busy right after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while previous event in progress");

  // errors never credit a total
  a_err_no_credit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.credited |-> out_data.status == etp_pkg::ST_OK)
    else $error("credit reported with error status");

  // an end on an empty stack leaves it empty
  a_empty_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == etp_pkg::ST_EMPTY |-> out_data.stack_depth == 8'd0)
    else $error("empty-stack error with nonzero depth");

endmodule

bind exclusive_time_profiler etp_checker u_etp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: tb/sv/testbench.sv
// testbench: self-checking bench for exclusive_time_profiler, depends on etp_pkg
// sends call-trace events over the valid/stall input channel and compares each result
// transaction with an in-bench profiler that tracks the call stack, time mark and totals

module testbench;

  localparam logic [1:0] MODE_READ     = 2'd2;
  localparam logic [1:0] MODE_READ_ALT = 2'd3;
  localparam int         CYCLE_LIMIT   = 500000;
  localparam int         PHASE_ITEMS   = 585;
  localparam int         DRAIN_CYCLES  = 20;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  etp_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  etp_pkg::out_t out_data;

  // profiler state as seen by the bench
  logic [31:0] func_totals [etp_pkg::NUM_FUNCS_DEF];
  logic [6:0]  active_ids [etp_pkg::STACK_DEPTH_DEF];
  int unsigned active_count = 0;
  logic [32:0] time_mark = '0;

  etp_pkg::out_t expected_results [$];
  int   mismatch_count     = 0;
  int   cycle_count        = 0;
  int   sender_idle_pct    = 26;
  int   receiver_stall_pct = 46;
  int   hold_off_cycles    = 0;
  int   depth_goal         = 4;

  exclusive_time_profiler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic etp_pkg::in_t trace_event(logic [1:0] mode, logic [6:0] id,
                                               logic [31:0] ts);
    etp_pkg::in_t ev;
    ev.mode        = mode;
    ev.function_id = id;
    ev.timestamp   = ts;
    return ev;
  endfunction

  // add elapsed time to the function on top of the stack, clamped at all ones
  function automatic etp_pkg::out_t credit_top(logic [32:0] amount, etp_pkg::out_t res);
    logic [6:0]  top;
    logic [33:0] sum;
    top = active_ids[active_count - 1];
    sum = {2'b00, func_totals[top]} + {1'b0, amount};
    func_totals[top] = (sum > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    res.credited    = 1'b1;
    res.credited_id = top;
    res.total       = func_totals[top];
    return res;
  endfunction

  function automatic etp_pkg::out_t profile_event(etp_pkg::in_t ev);
    etp_pkg::out_t res;
    logic [32:0]   now;
    res = '0;
    now = {1'b0, ev.timestamp};
    if (ev.mode[etp_pkg::MODE_READ_BIT]) begin
      res.credited_id = ev.function_id;
      res.total       = func_totals[ev.function_id];
    end else if (ev.mode == etp_pkg::MODE_START) begin
      if (active_count >= etp_pkg::STACK_DEPTH_DEF) begin
        res.status = etp_pkg::ST_FULL;
      end else if (now < time_mark) begin
        res.status = etp_pkg::ST_BACK;
      end else begin
        if (active_count != 0) res = credit_top(now - time_mark, res);
        active_ids[active_count] = ev.function_id;
        active_count++;
        time_mark = now;
      end
    end else begin
      if (active_count == 0) begin
        res.status = etp_pkg::ST_EMPTY;
      end else if (now + 33'd1 < time_mark) begin
        res.status = etp_pkg::ST_BACK;
      end else begin
        res = credit_top(now + 33'd1 - time_mark, res);
        active_count--;
        time_mark = now + 33'd1;
      end
    end
    res.stack_depth = active_count[7:0];
    return res;
  endfunction

  task automatic send_event(input etp_pkg::in_t ev);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(profile_event(ev));
  endtask

  task automatic pause_input();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_result(input etp_pkg::out_t got);
    etp_pkg::out_t want;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("result with nothing pending: %p", got);
    end else begin
      want = expected_results.pop_front();
      if (got.status !== want.status || got.credited !== want.credited ||
          got.credited_id !== want.credited_id || got.total !== want.total ||
          got.stack_depth !== want.stack_depth) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch: expected st %0d cr %0b id %0d tot %0d dep %0d, %s",
                   want.status, want.credited, want.credited_id, want.total,
                   want.stack_depth,
                   $sformatf("got %0d %0b %0d %0d %0d", got.status, got.credited,
                             got.credited_id, got.total, got.stack_depth));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (hold_off_cycles != 0) begin
        hold_off_cycles = hold_off_cycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
    end
  end

  task automatic random_event();
    int          pick;
    int          gap;
    logic [6:0]  id;
    logic [31:0] base;
    logic [31:0] ts;
    pick = $urandom_range(99);
    id   = 7'($urandom_range(127));
    base = time_mark[31:0];
    gap  = ($urandom_range(19) == 0) ? $urandom_range(4000) : $urandom_range(12);
    if ($urandom_range(49) == 0)
      depth_goal = ($urandom_range(5) == 0) ? etp_pkg::STACK_DEPTH_DEF : $urandom_range(16);
    if (pick < 18) begin
      send_event(trace_event(pick[0] ? MODE_READ_ALT : MODE_READ, id, $urandom));
    end else if (pick < 92) begin
      if ((active_count < depth_goal) ? (pick < 70) : (pick < 35)) begin
        send_event(trace_event(etp_pkg::MODE_START, id, base + gap));
      end else begin
        ts = (base + gap == 0) ? 32'd0 : base + gap - 1;
        send_event(trace_event(etp_pkg::MODE_END, id, ts));
      end
    end else if (base > 20) begin
      // timestamps behind the mark
      if (pick[0])
        send_event(trace_event(etp_pkg::MODE_START, id, base - 1 - $urandom_range(9)));
      else
        send_event(trace_event(etp_pkg::MODE_END, id, base - 2 - $urandom_range(9)));
    end else begin
      send_event(trace_event(MODE_READ, id, $urandom));
    end
  endtask

  task automatic test_reset_state();
    send_event(trace_event(MODE_READ, 7'd0, 32'd0));
    send_event(trace_event(MODE_READ_ALT, 7'd127, 32'hFFFF_FFFF));
    send_event(trace_event(etp_pkg::MODE_END, 7'd42, 32'd0));
  endtask

  task automatic test_nested_calls();
    send_event(trace_event(etp_pkg::MODE_START, 7'd5, 32'd0));
    send_event(trace_event(etp_pkg::MODE_START, 7'd127, 32'd3));
    send_event(trace_event(etp_pkg::MODE_START, 7'd0, 32'd3));
    send_event(trace_event(etp_pkg::MODE_END, 7'd0, 32'd9));
    send_event(trace_event(etp_pkg::MODE_END, 7'd0, 32'd9));
    send_event(trace_event(etp_pkg::MODE_END, 7'd0, 32'd12));
    send_event(trace_event(MODE_READ, 7'd5, 32'd0));
    send_event(trace_event(MODE_READ_ALT, 7'd127, 32'd0));
    send_event(trace_event(MODE_READ, 7'd0, 32'd0));
  endtask

  task automatic test_time_backwards();
    send_event(trace_event(etp_pkg::MODE_START, 7'd9, 32'd20));
    send_event(trace_event(etp_pkg::MODE_START, 7'd1, 32'd19));
    send_event(trace_event(etp_pkg::MODE_END, 7'd0, 32'd18));
    send_event(trace_event(etp_pkg::MODE_END, 7'd0, 32'd19));
    send_event(trace_event(etp_pkg::MODE_END, 7'd0, 32'd30));
    send_event(trace_event(etp_pkg::MODE_START, 7'd3, 32'd19));
    send_event(trace_event(etp_pkg::MODE_START, 7'd3, 32'd25));
    send_event(trace_event(etp_pkg::MODE_END, 7'd0, 32'd25));
  endtask

  task automatic test_stack_overflow();
    while (active_count < etp_pkg::STACK_DEPTH_DEF)
      send_event(trace_event(etp_pkg::MODE_START, 7'($urandom_range(127)),
                             time_mark[31:0] + $urandom_range(3)));
    send_event(trace_event(etp_pkg::MODE_START, 7'd77, time_mark[31:0] + 5));
    send_event(trace_event(MODE_READ, 7'd77, 32'd0));
    repeat (12)
      send_event(trace_event(etp_pkg::MODE_END, 7'd0, time_mark[31:0] + $urandom_range(4)));
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    hold_off_cycles = 300;
    repeat (40) random_event();
    pause_input();
    sender_idle_pct = 26;
  endtask

  task automatic test_random();
    sender_idle_pct    = 26;
    receiver_stall_pct = 46;
    repeat (PHASE_ITEMS) random_event();
    sender_idle_pct    = 46;
    receiver_stall_pct = 26;
    repeat (PHASE_ITEMS) random_event();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (PHASE_ITEMS) random_event();
    pause_input();
  endtask

  task automatic test_late_timestamps();
    while (active_count > etp_pkg::STACK_DEPTH_DEF - 8)
      send_event(trace_event(etp_pkg::MODE_END, 7'd0, time_mark[31:0]));
    send_event(trace_event(etp_pkg::MODE_START, 7'h55, time_mark[31:0]));
    send_event(trace_event(etp_pkg::MODE_START, 7'h2A, 32'h8000_0000));
    send_event(trace_event(etp_pkg::MODE_START, 7'h7F, 32'hFFFF_FFFF));
    send_event(trace_event(etp_pkg::MODE_END, 7'd0, 32'hFFFF_FFFF));
    // mark is now past the largest timestamp
    send_event(trace_event(etp_pkg::MODE_START, 7'd0, 32'hFFFF_FFFF));
    send_event(trace_event(etp_pkg::MODE_END, 7'd0, 32'hFFFF_FFFE));
    send_event(trace_event(etp_pkg::MODE_END, 7'd0, 32'hFFFF_FFFF));
    send_event(trace_event(MODE_READ_ALT, 7'h2A, 32'd0));
    send_event(trace_event(MODE_READ, 7'h7F, 32'd0));
    pause_input();
  endtask

  initial begin
    foreach (func_totals[i]) func_totals[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_nested_calls();
    test_time_backwards();
    test_stack_overflow();
    test_backpressure();
    test_random();
    test_late_timestamps();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/etp_pkg.sv
rtl/etp_alu.sv
rtl/exclusive_time_profiler.sv
rtl/etp_checker.sv
tb/sv/testbench.sv
